FILE: rtl/rlfs_pkg.sv
// shared types and constants for the rgb led frame serializer
package rlfs_pkg;

   // frame layout
   localparam int START_BYTES_DEF = 12;
   localparam int END_BYTES_DEF   = 12;
   localparam int LED_COUNT       = 3;
   localparam int LED_BYTES       = LED_COUNT * 4;
   localparam int LED_IDX_W       = 4;

   // frame byte values
   localparam logic [7:0] START_BYTE  = 8'h00;
   localparam logic [7:0] END_BYTE    = 8'hFF;
   localparam logic [7:0] HEADER_ON   = 8'hFF;
   localparam logic [7:0] HEADER_OFF  = 8'hE0;

   // input item
   typedef struct packed {
      logic       mode;
      logic [1:0] led_select;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] wheel_position;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // item modes
   localparam logic MODE_SET   = 1'b0;
   localparam logic MODE_WHEEL = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_LED,
      ST_END
   } state_type;

   // byte source select
   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_LED,
      SEL_ONES
   } byte_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic                 capture;
      logic                 load;
      byte_sel_type         sel;
      logic [LED_IDX_W-1:0] idx;
      logic                 last;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

FILE: rtl/rlfs_ctrl.sv
// frame sequencing controller: phase state machine and byte counter
module rlfs_ctrl #(
   parameter int START_BYTES = rlfs_pkg::START_BYTES_DEF,
   parameter int END_BYTES   = rlfs_pkg::END_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rlfs_pkg::status_type status,
   output rlfs_pkg::cmd_type    cmd
);
   import rlfs_pkg::*;

   localparam int MAX_PHASE = (START_BYTES > END_BYTES) ?
                              ((START_BYTES > LED_BYTES) ? START_BYTES : LED_BYTES) :
                              ((END_BYTES > LED_BYTES) ? END_BYTES : LED_BYTES);
   localparam int CNT_W = $clog2(MAX_PHASE);

   localparam logic [CNT_W-1:0] START_LAST = CNT_W'(START_BYTES - 1);
   localparam logic [CNT_W-1:0] LED_LAST   = CNT_W'(LED_BYTES - 1);
   localparam logic [CNT_W-1:0] END_LAST   = CNT_W'(END_BYTES - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             end_done;

   // final end byte goes out this cycle
   assign end_done = (state_ff == ST_END) && (cnt_ff == END_LAST) && status.out_free;

   // next state and counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = ST_START;
               cnt_in   = '0;
            end
         end
         ST_START: begin
            if (status.out_free) begin
               if (cnt_ff == START_LAST) begin
                  state_in = ST_LED;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_LED: begin
            if (status.out_free) begin
               if (cnt_ff == LED_LAST) begin
                  state_in = ST_END;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_END: begin
            if (status.out_free) begin
               if (cnt_ff == END_LAST) begin
                  state_in = (req_valid && req_ready) ? ST_START : ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // command outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.load    = 1'b0;
      cmd.sel     = SEL_ZERO;
      cmd.idx     = cnt_ff[LED_IDX_W-1:0];
      cmd.last    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_START: begin
            cmd.load = status.out_free;
            cmd.sel  = SEL_ZERO;
         end
         ST_LED: begin
            cmd.load = status.out_free;
            cmd.sel  = SEL_LED;
         end
         ST_END: begin
            cmd.load  = status.out_free;
            cmd.sel   = SEL_ONES;
            cmd.last  = (cnt_ff == END_LAST);
            req_ready = end_done;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.capture = req_valid && req_ready;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // checks
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("byte loaded while output register is full");

   a_capture_phase: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (state_ff == ST_IDLE || state_ff == ST_END))
      else $error("item taken in the middle of a frame");

   a_last_on_end: assert property (@(posedge clock) disable iff (reset)
      cmd.last && cmd.load |-> cmd.sel == SEL_ONES)
      else $error("last flag outside the end phase");

   a_led_to_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LED && cmd.load && cnt_ff == LED_LAST) |=> state_ff == ST_END)
      else $error("led phase did not hand over to end phase");

endmodule

FILE: rtl/rlfs_datapath.sv
// color store, wheel color, frame byte select and output register
module rlfs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rlfs_pkg::req_type    req_data,
   input  rlfs_pkg::cmd_type    cmd,
   output rlfs_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rlfs_pkg::rsp_type    rsp_data
);
   import rlfs_pkg::*;

   logic [23:0] color_ff [LED_COUNT];
   logic [23:0] shown_ff [LED_COUNT];
   logic [23:0] wheel_rgb;
   logic [23:0] set_rgb;
   logic [23:0] cur_led;
   logic [7:0]  byte_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   // rainbow color from a wheel position
   function automatic logic [23:0] wheel_color(input logic [7:0] position);
      logic [7:0] p;
      logic [7:0] q;
      logic [9:0] triple;
      logic [7:0] up;
      logic [7:0] down;
      p = 8'd255 - position;
      if (p < 8'd85) begin
         q = p;
      end else if (p < 8'd170) begin
         q = p - 8'd85;
      end else begin
         q = p - 8'd170;
      end
      triple = {2'b00, q} + {1'b0, q, 1'b0};
      up     = triple[7:0];
      down   = 8'd255 - up;
      if (p < 8'd85) begin
         wheel_color = {down, 8'h00, up};
      end else if (p < 8'd170) begin
         wheel_color = {8'h00, up, down};
      end else begin
         wheel_color = {up, down, 8'h00};
      end
   endfunction

   assign wheel_rgb = wheel_color(req_data.wheel_position);
   assign set_rgb   = {req_data.red_in, req_data.green_in, req_data.blue_in};

   // stored colors and the colors shown in this frame
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            color_ff[i] <= '0;
         end
      end else if (cmd.capture && req_data.mode == MODE_SET) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            if (req_data.led_select == 2'(i)) begin
               color_ff[i] <= set_rgb;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            if (req_data.mode == MODE_WHEEL) begin
               shown_ff[i] <= wheel_rgb;
            end else if (req_data.led_select == 2'(i)) begin
               shown_ff[i] <= set_rgb;
            end else begin
               shown_ff[i] <= color_ff[i];
            end
         end
      end
   end

   // byte select: led in upper index bits, header/red/green/blue in lower
   assign cur_led = shown_ff[cmd.idx[3:2]];

   always_comb begin
      byte_in = START_BYTE;
      case (cmd.sel)
         SEL_ZERO: byte_in = START_BYTE;
         SEL_ONES: byte_in = END_BYTE;
         SEL_LED: begin
            case (cmd.idx[1:0])
               2'd0:    byte_in = (cur_led != 24'h0) ? HEADER_ON : HEADER_OFF;
               2'd1:    byte_in = cur_led[23:16];
               2'd2:    byte_in = cur_led[15:8];
               default: byte_in = cur_led[7:0];
            endcase
         end
         default: byte_in = START_BYTE;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff.out_byte  <= byte_in;
         rsp_data_ff.last_byte <= cmd.last;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   // checks
   a_header_value: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.sel == SEL_LED && cmd.idx[1:0] == 2'd0)
      |=> (rsp_data.out_byte == HEADER_ON || rsp_data.out_byte == HEADER_OFF))
      else $error("bad led header byte");

   a_bad_select_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && req_data.led_select == 2'd3)
      |=> (color_ff[0] == $past(color_ff[0]) && color_ff[1] == $past(color_ff[1])
           && color_ff[2] == $past(color_ff[2])))
      else $error("out of range select changed a stored color");

   a_wheel_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && req_data.mode == MODE_WHEEL)
      |=> (color_ff[0] == $past(color_ff[0]) && color_ff[1] == $past(color_ff[1])
           && color_ff[2] == $past(color_ff[2])))
      else $error("wheel item changed a stored color");

endmodule

FILE: rtl/rgb_led_frame_serializer_top.sv
// rgb led frame serializer: three stored led colors or a wheel color sent as a led frame
// the taken item is held in the shown colors; its bytes go out via the output register
// each item sends START_BYTES + 12 + END_BYTES bytes (36 by default), one byte per cycle
// set by the byte counter; the next item is taken as the last byte loads
// output stalls hold the frame and stretch the item time by the stalled cycles
// reset (synchronous, active high) clears all stored colors to black and idles
module rgb_led_frame_serializer_top #(
   parameter int START_BYTES = rlfs_pkg::START_BYTES_DEF,
   parameter int END_BYTES   = rlfs_pkg::END_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rlfs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rlfs_pkg::rsp_type rsp_data
);
   import rlfs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // frame sequencing
   rlfs_ctrl #(
      .START_BYTES (START_BYTES),
      .END_BYTES   (END_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // colors and output bytes
   rlfs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
